[rtl/vpcn_pkg.sv]
// Shared types, constants and saturating helpers for the path command normalizer.
package vpcn_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int ARG_COUNT   = 6;
   localparam int TDATA_WIDTH = ((ARG_COUNT * COORD_WIDTH + 7) / 8) * 8;
   localparam int OP_WIDTH    = 4;
   localparam int KIND_WIDTH  = 2;

   // Two-thirds divider: q - p is biased by 3 * 2^COORD_WIDTH so it stays
   // positive, then split into a high and a low part around 2^LO_WIDTH.
   localparam int WIDE_WIDTH  = COORD_WIDTH + 3;
   localparam int LO_WIDTH    = (WIDE_WIDTH + 1) / 2;
   localparam int HI_WIDTH    = WIDE_WIDTH - LO_WIDTH;
   localparam int LO_MOD3     = (LO_WIDTH % 2 == 1) ? 2 : 1;
   localparam longint unsigned LO_POW = 64'd1 << LO_WIDTH;
   localparam logic [LO_WIDTH-1:0] TWO_K = LO_WIDTH'(2 * ((LO_POW - LO_MOD3) / 3));
   localparam int SMALL_WIDTH = LO_WIDTH + 3;
   localparam int RECIP_SHIFT = SMALL_WIDTH + 1;
   localparam logic [SMALL_WIDTH-1:0] RECIP =
      SMALL_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd2) / 3);
   localparam logic [WIDE_WIDTH-1:0] DIV_OFFSET = {3'b011, {COORD_WIDTH{1'b0}}};

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_MOVE       = 4'd0,
      OP_LINE       = 4'd1,
      OP_LINE_REL   = 4'd2,
      OP_HORIZ      = 4'd3,
      OP_HORIZ_REL  = 4'd4,
      OP_VERT       = 4'd5,
      OP_VERT_REL   = 4'd6,
      OP_CUBIC      = 4'd7,
      OP_CUBIC_REL  = 4'd8,
      OP_SCUBIC     = 4'd9,
      OP_SCUBIC_REL = 4'd10,
      OP_QUAD       = 4'd11,
      OP_QUAD_REL   = 4'd12,
      OP_SQUAD      = 4'd13,
      OP_SQUAD_REL  = 4'd14,
      OP_CLOSE      = 4'd15
   } op_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_MOVE  = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_CURVE = 2'd2,
      KIND_CLOSE = 2'd3
   } kind_type;

   typedef struct packed {
      op_type                     op;
      coord_type [ARG_COUNT-1:0]  arg;
   } cmd_type;

   // For a quadratic, ax/ay carry the pen and bx/by the quadratic control
   // until the two-thirds stage turns them into cubic controls.
   typedef struct packed {
      kind_type  kind;
      logic      quad;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type ex;
      coord_type ey;
   } prim_type;

   function automatic coord_type sat_wide(input logic signed [COORD_WIDTH+1:0] v);
      logic signed [COORD_WIDTH+1:0] hi_lim;
      logic signed [COORD_WIDTH+1:0] lo_lim;
      hi_lim = {3'b000, {(COORD_WIDTH-1){1'b1}}};
      lo_lim = {3'b111, {(COORD_WIDTH-1){1'b0}}};
      if (v > hi_lim) begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (v < lo_lim) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return v[COORD_WIDTH-1:0];
      end
   endfunction

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      return sat_wide({{2{a[COORD_WIDTH-1]}}, a} + {{2{b[COORD_WIDTH-1]}}, b});
   endfunction

   // 2*p - c, saturated.
   function automatic coord_type reflect(input coord_type p, input coord_type c);
      return sat_wide({p[COORD_WIDTH-1], p, 1'b0} - {{2{c[COORD_WIDTH-1]}}, c});
   endfunction

endpackage

[rtl/vector_path_command_normalizer_top.sv]
// Top level: stream ports, pipeline valid chain and the output register.
// A command beat passes through cmd_ff, prim2_ff and prim3_ff into out_ff before it shows on rsp_tdata.
// Throughput: one command per cycle while rsp_tready takes results; the path state loop
// closes within the first stage, and the two-thirds multiplies take the two stages after it.
// Each stage takes a new beat when it is empty or moving on, so bubbles are filled under stall.
// Reset clears the stage valid bits and the path state (pen, subpath, controls, last command).
module vector_path_command_normalizer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vpcn_pkg::TDATA_WIDTH-1:0] req_tdata,  // arg0, arg1, arg2, arg3, arg4, arg5
   input  logic [vpcn_pkg::OP_WIDTH-1:0]    req_tuser,  // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
   output logic [vpcn_pkg::TDATA_WIDTH-1:0] rsp_tdata,
   output logic [vpcn_pkg::KIND_WIDTH-1:0]  rsp_tuser   // kind
);

   logic                s1_valid_ff;
   logic                s2_valid_ff;
   logic                s3_valid_ff;
   logic                rsp_valid_ff;
   vpcn_pkg::cmd_type   cmd_ff, cmd_in;
   vpcn_pkg::prim_type  prim_a;
   vpcn_pkg::prim_type  prim2_ff;
   vpcn_pkg::prim_type  prim3_ff;
   vpcn_pkg::prim_type  out_ff, out_in;
   vpcn_pkg::coord_type tt_ax;
   vpcn_pkg::coord_type tt_ay;
   vpcn_pkg::coord_type tt_bx;
   vpcn_pkg::coord_type tt_by;

   logic space1;
   logic space2;
   logic space3;
   logic space4;

   always_comb begin
      space4 = !rsp_valid_ff || rsp_tready;
      space3 = !s3_valid_ff  || space4;
      space2 = !s2_valid_ff  || space3;
      space1 = !s1_valid_ff  || space2;
   end

   assign req_tready = space1;

   always_comb begin
      cmd_in.op = vpcn_pkg::op_type'(req_tuser);
      for (int k = 0; k < vpcn_pkg::ARG_COUNT; k++) begin
         cmd_in.arg[k] = req_tdata[k*vpcn_pkg::COORD_WIDTH +: vpcn_pkg::COORD_WIDTH];
      end
   end

   vpcn_absolute u_absolute (
      .clock (clock),
      .reset (reset),
      .load  (space2 && s1_valid_ff),
      .cmd   (cmd_ff),
      .prim  (prim_a)
   );

   vpcn_two_thirds u_tt_ax (
      .clock (clock),
      .load  (space3),
      .p     (prim2_ff.ax),
      .q     (prim2_ff.bx),
      .ctrl  (tt_ax)
   );

   vpcn_two_thirds u_tt_ay (
      .clock (clock),
      .load  (space3),
      .p     (prim2_ff.ay),
      .q     (prim2_ff.by),
      .ctrl  (tt_ay)
   );

   vpcn_two_thirds u_tt_bx (
      .clock (clock),
      .load  (space3),
      .p     (prim2_ff.ex),
      .q     (prim2_ff.bx),
      .ctrl  (tt_bx)
   );

   vpcn_two_thirds u_tt_by (
      .clock (clock),
      .load  (space3),
      .p     (prim2_ff.ey),
      .q     (prim2_ff.by),
      .ctrl  (tt_by)
   );

   always_comb begin
      out_in      = prim3_ff;
      out_in.quad = 1'b0;
      if (prim3_ff.quad) begin
         out_in.ax = tt_ax;
         out_in.ay = tt_ay;
         out_in.bx = tt_bx;
         out_in.by = tt_by;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (space1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (space2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (space3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (space4) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (space1) begin
         cmd_ff <= cmd_in;
      end
      if (space2) begin
         prim2_ff <= prim_a;
      end
      if (space3) begin
         prim3_ff <= prim2_ff;
      end
      if (space4) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = vpcn_pkg::TDATA_WIDTH'({out_ff.ey, out_ff.ex, out_ff.by,
                                                out_ff.bx, out_ff.ay, out_ff.ax});

   a_controls_zero_off_curve: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_ff.kind != vpcn_pkg::KIND_CURVE))
      |-> (out_ff.ax == '0) && (out_ff.ay == '0) && (out_ff.bx == '0) && (out_ff.by == '0))
      else $error("control points not zero on a non-curve result");

   a_close_has_no_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_ff.kind == vpcn_pkg::KIND_CLOSE))
      |-> (out_ff.ex == '0) && (out_ff.ey == '0))
      else $error("close result carries an end point");

   a_quad_is_curve: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && prim3_ff.quad) |-> (prim3_ff.kind == vpcn_pkg::KIND_CURVE))
      else $error("quadratic in the divider stage is not marked as a curve");

   a_result_from_pipeline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result appeared without a command in the last stage");

endmodule

[rtl/vpcn_two_thirds.sv]
// Two-stage p + floor(2*(q - p)/3) unit built from split constant multiplies.
module vpcn_two_thirds (
   input  logic                clock,
   input  logic                load,
   input  vpcn_pkg::coord_type p,
   input  vpcn_pkg::coord_type q,
   output vpcn_pkg::coord_type ctrl
);

   logic [vpcn_pkg::WIDE_WIDTH-1:0]                       diff;
   logic [vpcn_pkg::WIDE_WIDTH-1:0]                       wide;
   logic [vpcn_pkg::LO_WIDTH-1:0]                         lo_part;
   logic [vpcn_pkg::HI_WIDTH-1:0]                         hi_part;
   logic [vpcn_pkg::SMALL_WIDTH-1:0]                      small_sum;
   logic [vpcn_pkg::WIDE_WIDTH-1:0]                       hi_prod;
   logic [2*vpcn_pkg::SMALL_WIDTH-1:0]                    lo_prod;
   logic [vpcn_pkg::COORD_WIDTH-1:0]                      total;

   vpcn_pkg::coord_type                                   base_ff;
   logic [vpcn_pkg::COORD_WIDTH-1:0]                      hi_term_ff;
   logic [vpcn_pkg::SMALL_WIDTH-2:0]                      quot_ff;

   // With 2^LO = 3K + R, 2w = 3*(2K*hi) + (2R*hi + 2*lo), so only the small
   // remainder term needs a true divide by three.
   always_comb begin
      diff      = {{3{q[vpcn_pkg::COORD_WIDTH-1]}}, q} - {{3{p[vpcn_pkg::COORD_WIDTH-1]}}, p};
      wide      = diff + vpcn_pkg::DIV_OFFSET;
      lo_part   = wide[vpcn_pkg::LO_WIDTH-1:0];
      hi_part   = wide[vpcn_pkg::WIDE_WIDTH-1:vpcn_pkg::LO_WIDTH];
      small_sum = (vpcn_pkg::SMALL_WIDTH'(hi_part) << vpcn_pkg::LO_MOD3)
                + (vpcn_pkg::SMALL_WIDTH'(lo_part) << 1);
      hi_prod   = vpcn_pkg::WIDE_WIDTH'(hi_part) * vpcn_pkg::WIDE_WIDTH'(vpcn_pkg::TWO_K);
      lo_prod   = (2*vpcn_pkg::SMALL_WIDTH)'(small_sum)
                * (2*vpcn_pkg::SMALL_WIDTH)'(vpcn_pkg::RECIP);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         base_ff    <= p;
         hi_term_ff <= hi_prod[vpcn_pkg::COORD_WIDTH-1:0];
         quot_ff    <= lo_prod[vpcn_pkg::RECIP_SHIFT +: (vpcn_pkg::SMALL_WIDTH-1)];
      end
   end

   // The bias contributes 2^(COORD_WIDTH+1), which vanishes modulo the word.
   assign total = base_ff + hi_term_ff + vpcn_pkg::COORD_WIDTH'(quot_ff);
   assign ctrl  = total;

endmodule

[rtl/vpcn_absolute.sv]
// Path state and the conversion of one command into an absolute primitive.
module vpcn_absolute (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  vpcn_pkg::cmd_type  cmd,
   output vpcn_pkg::prim_type prim
);

   vpcn_pkg::coord_type pen_x_ff, pen_x_in;
   vpcn_pkg::coord_type pen_y_ff, pen_y_in;
   vpcn_pkg::coord_type subpath_x_ff, subpath_x_in;
   vpcn_pkg::coord_type subpath_y_ff, subpath_y_in;
   vpcn_pkg::coord_type last_quad_x_ff, last_quad_x_in;
   vpcn_pkg::coord_type last_quad_y_ff, last_quad_y_in;
   vpcn_pkg::coord_type last_cubic_x_ff, last_cubic_x_in;
   vpcn_pkg::coord_type last_cubic_y_ff, last_cubic_y_in;
   vpcn_pkg::op_type    prev_op_ff, prev_op_in;

   logic                rel;
   logic                cubic_prev;
   logic                quad_prev;
   vpcn_pkg::coord_type org_x;
   vpcn_pkg::coord_type org_y;
   vpcn_pkg::coord_type sum [vpcn_pkg::ARG_COUNT];
   vpcn_pkg::coord_type smooth_cx;
   vpcn_pkg::coord_type smooth_cy;
   vpcn_pkg::coord_type smooth_qx;
   vpcn_pkg::coord_type smooth_qy;

   always_comb begin
      rel = (cmd.op == vpcn_pkg::OP_LINE_REL)   || (cmd.op == vpcn_pkg::OP_HORIZ_REL)
         || (cmd.op == vpcn_pkg::OP_VERT_REL)   || (cmd.op == vpcn_pkg::OP_CUBIC_REL)
         || (cmd.op == vpcn_pkg::OP_SCUBIC_REL) || (cmd.op == vpcn_pkg::OP_QUAD_REL)
         || (cmd.op == vpcn_pkg::OP_SQUAD_REL);
      org_x = rel ? pen_x_ff : '0;
      org_y = rel ? pen_y_ff : '0;
      for (int k = 0; k < vpcn_pkg::ARG_COUNT; k++) begin
         sum[k] = vpcn_pkg::sat_add((k % 2 == 0) ? org_x : org_y, cmd.arg[k]);
      end
      cubic_prev = (prev_op_ff >= vpcn_pkg::OP_CUBIC) && (prev_op_ff <= vpcn_pkg::OP_SCUBIC_REL);
      quad_prev  = (prev_op_ff >= vpcn_pkg::OP_QUAD)  && (prev_op_ff <= vpcn_pkg::OP_SQUAD_REL);
      smooth_cx  = cubic_prev ? vpcn_pkg::reflect(pen_x_ff, last_cubic_x_ff) : pen_x_ff;
      smooth_cy  = cubic_prev ? vpcn_pkg::reflect(pen_y_ff, last_cubic_y_ff) : pen_y_ff;
      smooth_qx  = quad_prev  ? vpcn_pkg::reflect(pen_x_ff, last_quad_x_ff)  : pen_x_ff;
      smooth_qy  = quad_prev  ? vpcn_pkg::reflect(pen_y_ff, last_quad_y_ff)  : pen_y_ff;
   end

   always_comb begin
      prim            = '0;
      prim.kind       = vpcn_pkg::KIND_LINE;
      subpath_x_in    = subpath_x_ff;
      subpath_y_in    = subpath_y_ff;
      last_quad_x_in  = last_quad_x_ff;
      last_quad_y_in  = last_quad_y_ff;
      last_cubic_x_in = last_cubic_x_ff;
      last_cubic_y_in = last_cubic_y_ff;
      unique case (cmd.op)
         vpcn_pkg::OP_MOVE: begin
            prim.kind    = vpcn_pkg::KIND_MOVE;
            prim.ex      = cmd.arg[0];
            prim.ey      = cmd.arg[1];
            subpath_x_in = cmd.arg[0];
            subpath_y_in = cmd.arg[1];
         end
         vpcn_pkg::OP_LINE, vpcn_pkg::OP_LINE_REL: begin
            prim.ex = sum[0];
            prim.ey = sum[1];
         end
         vpcn_pkg::OP_HORIZ, vpcn_pkg::OP_HORIZ_REL: begin
            prim.ex = sum[0];
            prim.ey = pen_y_ff;
         end
         vpcn_pkg::OP_VERT, vpcn_pkg::OP_VERT_REL: begin
            prim.ex = pen_x_ff;
            prim.ey = vpcn_pkg::sat_add(org_y, cmd.arg[0]);
         end
         vpcn_pkg::OP_CUBIC, vpcn_pkg::OP_CUBIC_REL: begin
            prim.kind       = vpcn_pkg::KIND_CURVE;
            prim.ax         = sum[0];
            prim.ay         = sum[1];
            prim.bx         = sum[2];
            prim.by         = sum[3];
            prim.ex         = sum[4];
            prim.ey         = sum[5];
            last_cubic_x_in = sum[2];
            last_cubic_y_in = sum[3];
         end
         vpcn_pkg::OP_SCUBIC, vpcn_pkg::OP_SCUBIC_REL: begin
            prim.kind       = vpcn_pkg::KIND_CURVE;
            prim.ax         = smooth_cx;
            prim.ay         = smooth_cy;
            prim.bx         = sum[0];
            prim.by         = sum[1];
            prim.ex         = sum[2];
            prim.ey         = sum[3];
            last_cubic_x_in = sum[0];
            last_cubic_y_in = sum[1];
         end
         vpcn_pkg::OP_QUAD, vpcn_pkg::OP_QUAD_REL: begin
            prim.kind      = vpcn_pkg::KIND_CURVE;
            prim.quad      = 1'b1;
            prim.ax        = pen_x_ff;
            prim.ay        = pen_y_ff;
            prim.bx        = sum[0];
            prim.by        = sum[1];
            prim.ex        = sum[2];
            prim.ey        = sum[3];
            last_quad_x_in = sum[0];
            last_quad_y_in = sum[1];
         end
         vpcn_pkg::OP_SQUAD, vpcn_pkg::OP_SQUAD_REL: begin
            prim.kind      = vpcn_pkg::KIND_CURVE;
            prim.quad      = 1'b1;
            prim.ax        = pen_x_ff;
            prim.ay        = pen_y_ff;
            prim.bx        = smooth_qx;
            prim.by        = smooth_qy;
            prim.ex        = sum[0];
            prim.ey        = sum[1];
            last_quad_x_in = smooth_qx;
            last_quad_y_in = smooth_qy;
         end
         vpcn_pkg::OP_CLOSE: begin
            prim.kind = vpcn_pkg::KIND_CLOSE;
         end
      endcase
      pen_x_in   = (cmd.op == vpcn_pkg::OP_CLOSE) ? subpath_x_ff : prim.ex;
      pen_y_in   = (cmd.op == vpcn_pkg::OP_CLOSE) ? subpath_y_ff : prim.ey;
      prev_op_in = cmd.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff        <= '0;
         pen_y_ff        <= '0;
         subpath_x_ff    <= '0;
         subpath_y_ff    <= '0;
         last_quad_x_ff  <= '0;
         last_quad_y_ff  <= '0;
         last_cubic_x_ff <= '0;
         last_cubic_y_ff <= '0;
         prev_op_ff      <= vpcn_pkg::OP_CLOSE;
      end else if (load) begin
         pen_x_ff        <= pen_x_in;
         pen_y_ff        <= pen_y_in;
         subpath_x_ff    <= subpath_x_in;
         subpath_y_ff    <= subpath_y_in;
         last_quad_x_ff  <= last_quad_x_in;
         last_quad_y_ff  <= last_quad_y_in;
         last_cubic_x_ff <= last_cubic_x_in;
         last_cubic_y_ff <= last_cubic_y_in;
         prev_op_ff      <= prev_op_in;
      end
   end

   a_close_returns_pen: assert property (@(posedge clock) disable iff (reset)
      (load && (cmd.op == vpcn_pkg::OP_CLOSE))
      |=> (pen_x_ff == subpath_x_ff) && (pen_y_ff == subpath_y_ff))
      else $error("pen did not return to the subpath start after close");

   a_move_sets_subpath: assert property (@(posedge clock) disable iff (reset)
      (load && (cmd.op == vpcn_pkg::OP_MOVE))
      |=> (subpath_x_ff == pen_x_ff) && (subpath_y_ff == pen_y_ff))
      else $error("move did not set pen and subpath start together");

   a_curve_saves_control: assert property (@(posedge clock) disable iff (reset)
      (load && (cmd.op >= vpcn_pkg::OP_CUBIC) && (cmd.op <= vpcn_pkg::OP_SCUBIC_REL))
      |=> (last_cubic_x_ff == $past(prim.bx)) && (last_cubic_y_ff == $past(prim.by)))
      else $error("cubic command did not save its second control point");

endmodule
